>>> hw/rtl/fpf_pkg.sv
// Package for the fingerprint command packet framer: types, step codes and header constants.
package fpf_pkg;

	// Fixed header bytes of every command packet.
	localparam logic [7:0] HDR_FIRST  = 8'hEF;
	localparam logic [7:0] HDR_SECOND = 8'h01;

	// Reset value of the device address register.
	localparam logic [31:0] ADDR_RESET = 32'hFFFF_FFFF;

	// Output sequence steps for one input word.
	typedef enum logic [3:0] {
		STEP_HDR0    = 4'd0,
		STEP_HDR1    = 4'd1,
		STEP_ADDR0   = 4'd2,
		STEP_ADDR1   = 4'd3,
		STEP_ADDR2   = 4'd4,
		STEP_ADDR3   = 4'd5,
		STEP_ID      = 4'd6,
		STEP_LEN_HI  = 4'd7,
		STEP_LEN_LO  = 4'd8,
		STEP_PAYLOAD = 4'd9,
		STEP_SUM_HI  = 4'd10,
		STEP_SUM_LO  = 4'd11
	} step_t;

	// Everything the sequencer needs to emit the bytes caused by one input word.
	typedef struct packed {
		logic        start;     // word opens a packet, header goes first
		logic        last;      // word closes a packet, checksum follows
		logic [7:0]  id;
		logic [8:0]  field;     // length field, payload length plus two
		logic [7:0]  data;
		logic [15:0] sum;       // checksum including this word
	} item_t;

endpackage

>>> hw/rtl/fpf_pkt_state.sv
// Packet state of the framer: open flag, bytes left and running checksum.
module fpf_pkt_state
	import fpf_pkg::*;
#(
	parameter int MAX_PAYLOAD = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  packet_id,
	input  logic [7:0]  payload_length,
	input  logic [7:0]  payload_byte,
	output item_t       item
);

	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	logic        in_packet_q;
	logic [7:0]  bytes_left_q;
	logic [15:0] sum_q;

	logic [7:0]  len_sat;
	logic [8:0]  field;
	logic [15:0] sum_base;
	logic [7:0]  left_base;
	logic [15:0] sum_new;
	logic [7:0]  left_new;

	// Clamp the sampled length into the legal range and build the packet plan.
	always_comb begin
		len_sat = payload_length;
		if (len_sat == 8'd0) begin
			len_sat = 8'd1;
		end
		if (len_sat > MAX_LEN) begin
			len_sat = MAX_LEN;
		end
		field = {1'b0, len_sat} + 9'd2;
		if (in_packet_q) begin
			sum_base  = sum_q;
			left_base = bytes_left_q;
		end else begin
			sum_base  = {8'd0, packet_id} + {15'd0, field[8]} + {8'd0, field[7:0]};
			left_base = len_sat;
		end
		sum_new  = sum_base + {8'd0, payload_byte};
		left_new = left_base - 8'd1;

		item.start = !in_packet_q;
		item.last  = (left_new == 8'd0);
		item.id    = packet_id;
		item.field = field;
		item.data  = payload_byte;
		item.sum   = sum_new;
	end

	// Commit the packet state when a word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q  <= 1'b0;
			bytes_left_q <= 8'd0;
			sum_q        <= 16'd0;
		end else if (accept) begin
			in_packet_q  <= !item.last;
			bytes_left_q <= left_new;
			sum_q        <= item.last ? 16'd0 : sum_new;
		end
	end

endmodule

>>> hw/rtl/fingerprint_cmd_packet_framer.sv
// Top level of the fingerprint command packet framer.
//
// Usage: each word on the slave stream is one payload byte of a command.
// On the first word of a packet the block emits 0xEF 0x01, the four address
// bytes (least significant first), the id and the big-endian length field
// (payload length plus two), then the byte itself. Middle bytes pass through.
// After the last byte a 16-bit big-endian wrapping checksum follows.
// Throughput: one output word per cycle while m_tready is high. A middle byte
// emits itself; a packet's first byte emits header, address, id and length
// first, and a last byte adds the two checksum bytes, all from one sequencer.
// An input word is captured in the item register, then its first output
// word enters the output register once that is free. The next input word is
// taken while the last output word of the current one enters that register.
// Stall: when m_tready is low the output register holds and the sequencer
// and input side wait; nothing is dropped.
// Reset: no packet open, address register 0xFFFFFFFF. cfg_we writes the
// address; write it only while the block is idle.
module fingerprint_cmd_packet_framer
	import fpf_pkg::*;
#(
	parameter int MAX_PAYLOAD = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // packet_id, payload_length, payload_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte
	output logic        m_tuser,   // packet_end
	output logic        m_tlast    // run_end
);

	logic [31:0] module_address_q;
	item_t       item_next;
	item_t       item_q;
	logic        item_valid_q;
	step_t       step_q;
	step_t       step_last;
	logic        s_accept;
	logic        load;
	logic        item_done;
	logic [7:0]  byte_sel;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_pend_q;
	logic        out_last_q;

	// Device address register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_address_q <= ADDR_RESET;
		end else if (cfg_we) begin
			module_address_q <= cfg_wdata;
		end
	end

	fpf_pkt_state #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_state (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (s_accept),
		.packet_id     (s_tdata[7:0]),
		.payload_length(s_tdata[15:8]),
		.payload_byte  (s_tdata[23:16]),
		.item          (item_next)
	);

	// Handshake and sequencing control.
	always_comb begin
		step_last = item_q.last ? STEP_SUM_LO : STEP_PAYLOAD;
		load      = item_valid_q && (!out_valid_q || m_tready);
		item_done = load && (step_q == step_last);
		s_tready  = !item_valid_q || item_done;
		s_accept  = s_tvalid && s_tready;
	end

	// Pick the byte for the current step.
	always_comb begin
		case (step_q)
			STEP_HDR0:    byte_sel = HDR_FIRST;
			STEP_HDR1:    byte_sel = HDR_SECOND;
			STEP_ADDR0:   byte_sel = module_address_q[7:0];
			STEP_ADDR1:   byte_sel = module_address_q[15:8];
			STEP_ADDR2:   byte_sel = module_address_q[23:16];
			STEP_ADDR3:   byte_sel = module_address_q[31:24];
			STEP_ID:      byte_sel = item_q.id;
			STEP_LEN_HI:  byte_sel = {7'd0, item_q.field[8]};
			STEP_LEN_LO:  byte_sel = item_q.field[7:0];
			STEP_PAYLOAD: byte_sel = item_q.data;
			STEP_SUM_HI:  byte_sel = item_q.sum[15:8];
			STEP_SUM_LO:  byte_sel = item_q.sum[7:0];
			default:      byte_sel = item_q.data;
		endcase
	end

	// Item register and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_q <= 1'b0;
			step_q       <= STEP_HDR0;
		end else if (s_accept) begin
			item_valid_q <= 1'b1;
			step_q       <= item_next.start ? STEP_HDR0 : STEP_PAYLOAD;
		end else if (item_done) begin
			item_valid_q <= 1'b0;
		end else if (load) begin
			step_q <= step_t'(step_q + 4'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_q <= item_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= byte_sel;
			out_pend_q <= (step_q == STEP_SUM_LO);
			out_last_q <= (step_q == step_last);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_pend_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	// The low checksum byte always closes the run of its input word.
	a_pend_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("packet end without run end");

	// With no word in the sequencer the input side must be open.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!item_valid_q |-> s_tready)
		else $error("input stalled with empty sequencer");

	// The step counter never runs past the low checksum byte.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_q |-> (step_q <= STEP_SUM_LO))
		else $error("step counter out of range");

	// A word that continues a packet goes straight to the payload step.
	a_mid_step: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && !item_next.start |=> (step_q == STEP_PAYLOAD))
		else $error("continuation word did not start at payload");
`endif

endmodule

>>> bench/fingerprint_cmd_packet_framer_tb.sv
// Self-checking testbench for the fingerprint command packet framer.
`timescale 1ns / 1ps

module fingerprint_cmd_packet_framer_tb;
	import fpf_pkg::*;

	localparam int MAX_PAYLOAD = 128;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DIR_ROWS    = 15;
	localparam int PHASES      = 4;
	localparam int PHASE_WORDS = 35;

	// One framed output word as it should leave the block.
	typedef struct {
		logic [7:0] out_byte;
		logic       packet_end;
		logic       run_end;
	} framed_t;

	// One directed input word; a typed checksum is given where it is obvious.
	typedef struct packed {
		logic [7:0]  id;
		logic [7:0]  len;
		logic [7:0]  data;
		logic        sum_given;
		logic [15:0] sum;
	} dir_row_t;

	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{8'h00, 8'h00, 8'h00, 1'b1, 16'h0003},  // zero length, all zeros
		'{8'hFF, 8'h01, 8'hFF, 1'b1, 16'h0201},  // one byte, all ones
		'{8'h5A, 8'h03, 8'h11, 1'b0, 16'h0000},  // three byte packet
		'{8'hA5, 8'h00, 8'h22, 1'b0, 16'h0000},  // id and length ignored inside
		'{8'h33, 8'hFF, 8'h33, 1'b0, 16'h0000},
		'{8'h80, 8'h02, 8'h80, 1'b0, 16'h0000},
		'{8'h7F, 8'h80, 8'h7F, 1'b0, 16'h0000},
		'{8'hC3, 8'h01, 8'h00, 1'b1, 16'h00C6},
		'{8'h3C, 8'h04, 8'hAA, 1'b0, 16'h0000},
		'{8'h55, 8'h00, 8'h55, 1'b0, 16'h0000},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 16'h0000},
		'{8'h00, 8'h00, 8'h00, 1'b0, 16'h0000},
		'{8'h12, 8'h02, 8'hFE, 1'b0, 16'h0000},
		'{8'h34, 8'h01, 8'h01, 1'b0, 16'h0000},
		'{8'h96, 8'h00, 8'h69, 1'b1, 16'h0102}   // zero length taken as one
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;    // packet_id, payload_length, payload_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;    // out_byte
	logic        m_tuser;    // packet_end
	logic        m_tlast;    // run_end

	// Framer state as the testbench sees it.
	logic [31:0] fr_addr;
	logic [7:0]  fr_left;
	logic [15:0] fr_sum;
	logic        fr_open;

	framed_t framed_q[$];
	framed_t want;
	int      mismatches;
	int      cycle_count;
	int      sent_words;
	bit      tx_burst;
	bit      rx_steady;

	fingerprint_cmd_packet_framer #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Free-running clock, 4 ns period.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void push_word(input logic [7:0] b, input logic pend, input logic rend);
		framed_t w;
		w.out_byte   = b;
		w.packet_end = pend;
		w.run_end    = rend;
		framed_q.push_back(w);
	endfunction

	// Works out the framed words caused by one payload word and queues them.
	function automatic void frame_word(input logic [7:0] id, input logic [7:0] len,
		input logic [7:0] data, input logic sum_given, input logic [15:0] sum_typed);
		logic [7:0]  n;
		logic [15:0] field;
		logic [15:0] sum;
		if (!fr_open) begin
			n = len;
			if (n == 8'd0)
				n = 8'd1;
			if (n > MAX_PAYLOAD)
				n = 8'(MAX_PAYLOAD);
			field = 16'(n) + 16'd2;
			push_word(HDR_FIRST, 1'b0, 1'b0);
			push_word(HDR_SECOND, 1'b0, 1'b0);
			for (int i = 0; i < 4; i++)
				push_word(fr_addr[8*i +: 8], 1'b0, 1'b0);
			push_word(id, 1'b0, 1'b0);
			push_word(field[15:8], 1'b0, 1'b0);
			push_word(field[7:0], 1'b0, 1'b0);
			fr_sum  = 16'(id) + 16'(field[15:8]) + 16'(field[7:0]);
			fr_left = n;
			fr_open = 1'b1;
		end
		fr_sum  = fr_sum + 16'(data);
		fr_left = fr_left - 8'd1;
		push_word(data, 1'b0, fr_left != 8'd0);
		if (fr_left == 8'd0) begin
			sum = sum_given ? sum_typed : fr_sum;
			push_word(sum[15:8], 1'b0, 1'b0);
			push_word(sum[7:0], 1'b1, 1'b1);
			fr_sum  = 16'd0;
			fr_open = 1'b0;
		end
	endfunction

	// Offers one payload word after a random gap, or none in a burst, and holds it until taken.
	task automatic send_word(input logic [7:0] id, input logic [7:0] len,
		input logic [7:0] data, input logic sum_given, input logic [15:0] sum_typed);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {data, len, id};
		frame_word(id, len, data, sum_given, sum_typed);
		sent_words++;
		do @(posedge clk); while (!s_tready);
	endtask

	// Sends one whole packet; fields after the first word carry random noise.
	task automatic send_packet(input logic [7:0] len_raw);
		int n;
		n = (len_raw == 8'd0) ? 1 : ((len_raw > MAX_PAYLOAD) ? MAX_PAYLOAD : len_raw);
		tx_burst = ($urandom_range(0, 3) == 0);
		send_word(8'($urandom), len_raw, 8'($urandom), 1'b0, 16'd0);
		for (int i = 1; i < n; i++)
			send_word(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 16'd0);
	endtask

	// Drops the input valid and waits until every queued word has come out.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (framed_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Output side: random ready stalls, with stretches of none.
	initial begin
		int stall;
		m_tready  = 1'b0;
		rx_steady = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 29) == 0)
				rx_steady = !rx_steady;
			stall = rx_steady ? 0 : $urandom_range(0, 10);
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Compare every accepted output word with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (framed_q.size() == 0) begin
				$error("unexpected word: out_byte %h packet_end %b run_end %b",
					m_tdata, m_tuser, m_tlast);
				mismatches++;
			end else begin
				want = framed_q.pop_front();
				if (m_tdata !== want.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte, m_tdata);
					mismatches++;
				end
				if (m_tuser !== want.packet_end) begin
					$error("packet_end: expected %b, got %b", want.packet_end, m_tuser);
					mismatches++;
				end
				if (m_tlast !== want.run_end) begin
					$error("run_end: expected %b, got %b", want.run_end, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Main sequence: reset, directed table, then random phases per address.
	initial begin
		logic [31:0] addr_set [PHASES];
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = 32'd0;
		s_tvalid    = 1'b0;
		s_tdata     = 24'd0;
		mismatches  = 0;
		cycle_count = 0;
		sent_words  = 0;
		tx_burst    = 1'b0;
		fr_addr     = ADDR_RESET;
		fr_left     = 8'd0;
		fr_sum      = 16'd0;
		fr_open     = 1'b0;
		addr_set[0] = 32'h0000_0000;
		addr_set[1] = $urandom;
		addr_set[2] = 32'hFFFF_FFFF;
		addr_set[3] = $urandom;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words under the reset address.
		for (int r = 0; r < DIR_ROWS; r++)
			send_word(DIR_TABLE[r].id, DIR_TABLE[r].len, DIR_TABLE[r].data,
				DIR_TABLE[r].sum_given, DIR_TABLE[r].sum);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			// New address while nothing is in flight.
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_wdata <= addr_set[ph];
			@(negedge clk);
			cfg_we    <= 1'b0;
			fr_addr = addr_set[ph];

			sent_words = 0;
			// One overlong packet that saturates to the largest payload.
			if (ph == 1)
				send_packet(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
			while (sent_words < PHASE_WORDS) begin
				if ($urandom_range(0, 11) == 0)
					send_packet(8'($urandom_range(10, 40)));
				else
					send_packet(8'($urandom_range(0, 9)));
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/fpf_pkg.sv
hw/rtl/fpf_pkt_state.sv
hw/rtl/fingerprint_cmd_packet_framer.sv
bench/fingerprint_cmd_packet_framer_tb.sv
